// File: src/tagged_interval_timer_table_macros.svh
// ----------------------------------------------------------------------------
// Tagged interval timer table: assertion macros
// Shared helpers for the concurrent checks of the timer table. They expect
// clk_i and rst_ni in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef TAGGED_INTERVAL_TIMER_TABLE_MACROS_SVH
`define TAGGED_INTERVAL_TIMER_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TITT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TITT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/titt_pkg.sv
// ----------------------------------------------------------------------------
// Tagged interval timer table: package
// Field widths, codes, payload types and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package titt_pkg;

  // Default table size.
  localparam int unsigned EntriesDefault = 16;

  // Field widths.
  localparam int unsigned KindW   = 2;
  localparam int unsigned TagW    = 32;
  localparam int unsigned TsW     = 63;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IdxOutW = 4;
  localparam int unsigned TotalW  = 64;
  localparam int unsigned CountW  = 32;
  localparam int unsigned StateW  = 2;

  // Item kinds.
  localparam logic [KindW-1:0] KindBegin = 2'd0;
  localparam logic [KindW-1:0] KindEnd   = 2'd1;
  localparam logic [KindW-1:0] KindClear = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk      = 3'd0;
  localparam logic [StatusW-1:0] StatusFull    = 3'd1;
  localparam logic [StatusW-1:0] StatusRunning = 3'd2;
  localparam logic [StatusW-1:0] StatusStopped = 3'd3;
  localparam logic [StatusW-1:0] StatusUnknown = 3'd4;

  // Entry states.
  localparam logic [StateW-1:0] StFree    = 2'd0;
  localparam logic [StateW-1:0] StRunning = 2'd1;
  localparam logic [StateW-1:0] StStopped = 2'd2;

  // Initial value of the smallest-duration pair.
  localparam logic [TotalW-1:0] MinInit = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [TagW-1:0]  tag_id;
    logic [TsW-1:0]   timestamp;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdxOutW-1:0] entry_index;
    logic [TsW-1:0]     duration;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic match;
    logic lookup;
    logic exec;
    logic update;
    logic sweep;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             sweep_last;
    logic             out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: src/titt_if.sv
// ----------------------------------------------------------------------------
// Tagged interval timer table: channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface titt_in_if;
  logic               valid;
  logic               ready;
  titt_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface titt_out_if;
  logic                valid;
  logic                ready;
  titt_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/titt_ctrl.sv
// ----------------------------------------------------------------------------
// Tagged interval timer table: controller
// Sequences one item at a time through match, lookup, execute and update,
// or through the statistics clearing sweep; an undefined kind skips both.
// ----------------------------------------------------------------------------
`default_nettype none

module titt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire titt_pkg::sts_t sts_i,
  output titt_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SMatch  = 3'd1;
  localparam logic [2:0] SLookup = 3'd2;
  localparam logic [2:0] SExec   = 3'd3;
  localparam logic [2:0] SUpdate = 3'd4;
  localparam logic [2:0] SSweep  = 3'd5;
  localparam logic [2:0] SDone   = 3'd6;

  logic [2:0] state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = SMatch;
        end
      end
      SMatch: begin
        cmd_o.match = 1'b1;
        if (sts_i.kind == titt_pkg::KindBegin || sts_i.kind == titt_pkg::KindEnd) begin
          state_d = SLookup;
        end else if (sts_i.kind == titt_pkg::KindClear) begin
          state_d = SSweep;
        end else begin
          state_d = SDone;
        end
      end
      SLookup: begin
        cmd_o.lookup = 1'b1;
        state_d      = SExec;
      end
      SExec: begin
        cmd_o.exec = 1'b1;
        state_d    = SUpdate;
      end
      SUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = SDone;
      end
      SSweep: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = SDone;
        end
      end
      SDone: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/titt_dp.sv
// ----------------------------------------------------------------------------
// Tagged interval timer table: datapath
// Entry table, tag match, statistics memories, duration arithmetic and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module titt_dp #(
  parameter int unsigned ENTRIES = titt_pkg::EntriesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire titt_pkg::cmd_t     cmd_i,
  output titt_pkg::sts_t          sts_o,
  input  wire titt_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output titt_pkg::out_item_t     out_item_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  localparam int unsigned TsW    = titt_pkg::TsW;
  localparam int unsigned TotalW = titt_pkg::TotalW;
  localparam int unsigned CountW = titt_pkg::CountW;
  localparam int unsigned StateW = titt_pkg::StateW;

  // Update actions decided in the execute step.
  localparam logic [1:0] ActNone    = 2'd0;
  localparam logic [1:0] ActRestart = 2'd1;
  localparam logic [1:0] ActAlloc   = 2'd2;
  localparam logic [1:0] ActStop    = 2'd3;

  // Entry table in flip-flops.
  logic [StateW-1:0]         entry_state_q [ENTRIES];
  logic [titt_pkg::TagW-1:0] entry_tag_q [ENTRIES];

  // Per-entry memories.
  logic [TsW-1:0]    start_mem [ENTRIES];
  logic [TotalW-1:0] total_mem [ENTRIES];
  logic [CountW-1:0] count_mem [ENTRIES];
  logic [TotalW-1:0] min0_mem  [ENTRIES];
  logic [TotalW-1:0] min1_mem  [ENTRIES];
  logic [TotalW-1:0] max0_mem  [ENTRIES];
  logic [TotalW-1:0] max1_mem  [ENTRIES];

  // Registered read data.
  logic [TsW-1:0]    start_rd_q;
  logic [TotalW-1:0] total_rd_q;
  logic [CountW-1:0] count_rd_q;
  logic [TotalW-1:0] min0_rd_q, min1_rd_q, max0_rd_q, max1_rd_q;

  titt_pkg::in_item_t  item_q;
  titt_pkg::out_item_t res_q, out_q;
  logic                out_valid_q;
  logic [ENTRIES-1:0]  match_q, free_q;
  logic [ENTRIES-1:0]  match_c, free_c;
  logic                hit_q, free_found_q;
  logic [IdxW-1:0]     idx_q, cnt_q;
  logic [StateW-1:0]   st_q;
  logic [TsW-1:0]      dur_q;
  logic [1:0]          act_q;

  logic [IdxW-1:0]     match_idx, free_idx, enc_idx, wr_addr;
  logic                hit_c, free_found_c;
  logic [IdxW+3:0]     idx_ext;
  logic [TsW-1:0]      dur_c;
  logic [TotalW-1:0]   dur_ext;
  logic                lt0, lt1, gt0, gt1;

  logic                state_we, tag_we, start_we, total_we, count_we;
  logic                min0_we, min1_we, max0_we, max1_we;
  logic [StateW-1:0]   state_wd;
  logic [TotalW-1:0]   total_wd, min0_wd, min1_wd, max0_wd, max1_wd;
  logic [CountW-1:0]   count_wd;

  // Tag compare against every used entry, and free-entry flags.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_c[i] = (entry_state_q[i] != titt_pkg::StFree) &&
                   (entry_tag_q[i] == item_q.tag_id);
      free_c[i]  = (entry_state_q[i] == titt_pkg::StFree);
    end
  end

  // Lowest-index priority encoders on the registered flags.
  always_comb begin
    match_idx    = '0;
    free_idx     = '0;
    hit_c        = 1'b0;
    free_found_c = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        match_idx = IdxW'(i);
        hit_c     = 1'b1;
      end
      if (free_q[i]) begin
        free_idx     = IdxW'(i);
        free_found_c = 1'b1;
      end
    end
  end

  assign enc_idx = hit_c ? match_idx : free_idx;
  assign idx_ext = {4'b0000, idx_q};
  assign dur_c   = item_q.timestamp - start_rd_q;
  assign dur_ext = {1'b0, dur_q};
  assign wr_addr = cmd_i.sweep ? cnt_q : idx_q;

  // Item, match flags, lookup result and sweep counter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
      cnt_q  <= '0;
    end
    if (cmd_i.match) begin
      match_q <= match_c;
      free_q  <= free_c;
    end
    if (cmd_i.lookup) begin
      hit_q        <= hit_c;
      free_found_q <= free_found_c;
      idx_q        <= enc_idx;
      st_q         <= entry_state_q[enc_idx];
    end
    if (cmd_i.sweep) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Execute step: status, index and duration of the result, and the action.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      res_q <= '0;
      act_q <= ActNone;
    end else if (cmd_i.exec) begin
      dur_q <= dur_c;
      if (item_q.kind == titt_pkg::KindBegin) begin
        if (hit_q) begin
          res_q.entry_index <= idx_ext[3:0];
          if (st_q != titt_pkg::StStopped) begin
            res_q.status <= titt_pkg::StatusRunning;
          end else begin
            act_q <= ActRestart;
          end
        end else if (free_found_q) begin
          res_q.entry_index <= idx_ext[3:0];
          act_q             <= ActAlloc;
        end else begin
          res_q.status <= titt_pkg::StatusFull;
        end
      end else begin
        if (!hit_q) begin
          res_q.status <= titt_pkg::StatusUnknown;
        end else if (st_q != titt_pkg::StRunning) begin
          res_q.status      <= titt_pkg::StatusStopped;
          res_q.entry_index <= idx_ext[3:0];
        end else begin
          res_q.entry_index <= idx_ext[3:0];
          res_q.duration    <= dur_c;
          act_q             <= ActStop;
        end
      end
    end
  end

  // Parallel compares of the duration against the stored extremes.
  assign lt0 = dur_ext < min0_rd_q;
  assign lt1 = dur_ext < min1_rd_q;
  assign gt0 = dur_ext > max0_rd_q;
  assign gt1 = dur_ext > max1_rd_q;

  // Write enables and data for the update step and the clearing sweep.
  always_comb begin
    state_we = 1'b0;
    tag_we   = 1'b0;
    start_we = 1'b0;
    total_we = 1'b0;
    count_we = 1'b0;
    min0_we  = 1'b0;
    min1_we  = 1'b0;
    max0_we  = 1'b0;
    max1_we  = 1'b0;
    state_wd = titt_pkg::StRunning;
    total_wd = '0;
    count_wd = '0;
    min0_wd  = titt_pkg::MinInit;
    min1_wd  = titt_pkg::MinInit;
    max0_wd  = '0;
    max1_wd  = '0;
    if (cmd_i.sweep) begin
      if (entry_state_q[cnt_q] != titt_pkg::StFree) begin
        total_we = 1'b1;
        count_we = 1'b1;
        min0_we  = 1'b1;
        min1_we  = 1'b1;
        max0_we  = 1'b1;
        max1_we  = 1'b1;
      end
    end else if (cmd_i.update) begin
      unique case (act_q)
        ActRestart: begin
          state_we = 1'b1;
          start_we = 1'b1;
          count_we = 1'b1;
          count_wd = count_rd_q + 1'b1;
        end
        ActAlloc: begin
          // Allocation rewrites the statistics of the entry and starts the count at one.
          state_we = 1'b1;
          tag_we   = 1'b1;
          start_we = 1'b1;
          total_we = 1'b1;
          count_we = 1'b1;
          count_wd = CountW'(1);
          min0_we  = 1'b1;
          min1_we  = 1'b1;
          max0_we  = 1'b1;
          max1_we  = 1'b1;
        end
        ActStop: begin
          state_we = 1'b1;
          state_wd = titt_pkg::StStopped;
          total_we = 1'b1;
          total_wd = total_rd_q + dur_ext;
          // The largest pair moves only when the smallest pair does not.
          if (lt1) begin
            if (lt0) begin
              min1_we = 1'b1;
              min1_wd = min0_rd_q;
              min0_we = 1'b1;
              min0_wd = dur_ext;
            end else begin
              min1_we = 1'b1;
              min1_wd = dur_ext;
            end
          end else if (gt1) begin
            if (gt0) begin
              max1_we = 1'b1;
              max1_wd = max0_rd_q;
              max0_we = 1'b1;
              max0_wd = dur_ext;
            end else begin
              max1_we = 1'b1;
              max1_wd = dur_ext;
            end
          end
        end
        default: begin
          state_we = 1'b0;
        end
      endcase
    end
  end

  // Entry states, cleared to free at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_state_q[i] <= titt_pkg::StFree;
      end
    end else if (state_we) begin
      entry_state_q[wr_addr] <= state_wd;
    end
  end

  // Tags, written on allocation.
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      entry_tag_q[wr_addr] <= item_q.tag_id;
    end
  end

  // Statistics memories: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (start_we) start_mem[wr_addr] <= item_q.timestamp;
    if (total_we) total_mem[wr_addr] <= total_wd;
    if (count_we) count_mem[wr_addr] <= count_wd;
    if (min0_we)  min0_mem[wr_addr]  <= min0_wd;
    if (min1_we)  min1_mem[wr_addr]  <= min1_wd;
    if (max0_we)  max0_mem[wr_addr]  <= max0_wd;
    if (max1_we)  max1_mem[wr_addr]  <= max1_wd;
    if (cmd_i.lookup) begin
      start_rd_q <= start_mem[enc_idx];
      total_rd_q <= total_mem[enc_idx];
      count_rd_q <= count_mem[enc_idx];
      min0_rd_q  <= min0_mem[enc_idx];
      min1_rd_q  <= min1_mem[enc_idx];
      max0_rd_q  <= max0_mem[enc_idx];
      max1_rd_q  <= max1_mem[enc_idx];
    end
  end

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_q;
  assign sts_o.kind       = item_q.kind;
  assign sts_o.sweep_last = (cnt_q == LastIdx);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// File: src/tagged_interval_timer_table.sv
// ----------------------------------------------------------------------------
// Tagged interval timer table: top level
// Items arrive on in_i (kind, tag, timestamp); one result per item leaves on
// out_o (status, entry index, duration). Both are valid/ready channels and
// a transfer happens when valid and ready are high at a rising edge.
// The block works on one item at a time. A begin or end item passes from its
// transfer to a valid result through tag compare, priority encode with the
// memory read, duration subtract, table update and result load.
// A clear item sweeps the statistics memories one entry per cycle; an
// undefined kind goes from the tag compare straight to the result load.
// The next item is taken as soon as the result is in the output register,
// so a new item may be accepted while the previous result still waits there.
// If the receiver stalls, the finished result of the following item waits in
// the datapath's result register until the output register frees up, and no
// further item is accepted.
// Reset is asynchronous and active low: it marks every entry free and
// empties the output register; no clearing pass is needed afterwards.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tagged_interval_timer_table_macros.svh"

module tagged_interval_timer_table #(
  parameter int unsigned ENTRIES = titt_pkg::EntriesDefault
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  titt_in_if.sink    in_i,
  titt_out_if.source out_o
);

  titt_pkg::cmd_t cmd;
  titt_pkg::sts_t sts;

  // Sequencer for one item at a time.
  titt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, memories and output register.
  titt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_i.payload),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.payload)
  );

  // Only one item is in flight after an input transfer.
  `TITT_ASSERT_NEXT(a_one_in_flight, in_i.valid && in_i.ready, !in_i.ready, "second item taken while busy")

  // Failed lookups report entry index zero.
  `TITT_ASSERT_SAME(a_fail_index_zero, out_o.valid && (out_o.payload.status == titt_pkg::StatusFull || out_o.payload.status == titt_pkg::StatusUnknown), out_o.payload.entry_index == '0, "nonzero index on failed lookup")

  // A duration is reported only with a good status.
  `TITT_ASSERT_SAME(a_dur_only_ok, out_o.valid && out_o.payload.status != titt_pkg::StatusOk, out_o.payload.duration == '0, "duration on failed item")

endmodule

`default_nettype wire
